@@ src/rict_pkg.sv @@
// ----------------------------------------------------------------------------
// rict_pkg
// Shared types, widths and codes for the reference-counted inode cache table.
// ----------------------------------------------------------------------------
package rict_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    // Slot numbers are six bits wide, so at most this many entries are usable.
    localparam int SLOT_LIMIT        = 64;

    localparam int SLOT_W   = 6;
    localparam int KEY_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLAIMED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LAST    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STILL   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADPUT  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SAT     = 3'd6;

    typedef enum logic [1:0] {
        STATE_IDLE,
        STATE_LOOK,
        STATE_UPDATE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic look;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dpath_stat_t;

endpackage

@@ src/rict_ctrl.sv @@
// ----------------------------------------------------------------------------
// rict_ctrl
// Sequencer: capture an item, run the table lookup, then apply the update
// once the output register can take the result.
// ----------------------------------------------------------------------------
module rict_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  rict_pkg::dpath_stat_t stat,
    output rict_pkg::ctrl_cmd_t   cmd
);

    rict_pkg::state_t state_reg;
    rict_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rict_pkg::STATE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rict_pkg::STATE_IDLE: begin
                if (s_tvalid) begin
                    state_next = rict_pkg::STATE_LOOK;
                end
            end
            rict_pkg::STATE_LOOK: begin
                state_next = rict_pkg::STATE_UPDATE;
            end
            rict_pkg::STATE_UPDATE: begin
                if (stat.out_free) begin
                    state_next = s_tvalid ? rict_pkg::STATE_LOOK : rict_pkg::STATE_IDLE;
                end
            end
            default: begin
                state_next = rict_pkg::STATE_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.look    = 1'b0;
        cmd.update  = 1'b0;
        case (state_reg)
            rict_pkg::STATE_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            rict_pkg::STATE_LOOK: begin
                cmd.look = 1'b1;
            end
            rict_pkg::STATE_UPDATE: begin
                // The next item may enter in the same cycle the result is stored.
                s_tready    = stat.out_free;
                cmd.update  = stat.out_free;
                cmd.load_in = stat.out_free & s_tvalid;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ src/rict_dpath.sv @@
// ----------------------------------------------------------------------------
// rict_dpath
// Entry table (keys and counts), parallel match and first-free pick, count
// update and the output register.
// ----------------------------------------------------------------------------
module rict_dpath #(
    parameter int TABLE_ENTRIES = rict_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rict_pkg::ctrl_cmd_t                 cmd,
    output rict_pkg::dpath_stat_t               stat,
    input  logic                                in_command,
    input  logic [rict_pkg::KEY_W-1:0]          in_number,
    input  logic [rict_pkg::SLOT_W-1:0]         in_slot,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rict_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [rict_pkg::STATUS_W-1:0]       m_tuser
);

    localparam int SLOTS = (TABLE_ENTRIES < rict_pkg::SLOT_LIMIT) ?
                           TABLE_ENTRIES : rict_pkg::SLOT_LIMIT;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int PAD_W = rict_pkg::M_TDATA_W - rict_pkg::SLOT_W - rict_pkg::KEY_W
                           - rict_pkg::COUNT_W;

    // Captured item
    logic                         cmd_reg;
    logic [rict_pkg::KEY_W-1:0]   num_reg;
    logic [rict_pkg::SLOT_W-1:0]  slot_reg;

    // Table
    logic [rict_pkg::KEY_W-1:0]   key_reg  [SLOTS];
    logic [rict_pkg::COUNT_W-1:0] refs_reg [SLOTS];

    // Lookup results
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic             hit_next;
    logic [IDX_W-1:0] hit_idx_next;
    logic             free_next;
    logic [IDX_W-1:0] free_idx_next;

    // Output register
    logic                          m_tvalid_reg;
    logic [rict_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [rict_pkg::STATUS_W-1:0] out_status_reg;
    logic [rict_pkg::KEY_W-1:0]    out_number_reg;
    logic [rict_pkg::COUNT_W-1:0]  out_count_reg;

    logic [rict_pkg::SLOT_W-1:0]   out_slot_next;
    logic [rict_pkg::STATUS_W-1:0] out_status_next;
    logic [rict_pkg::KEY_W-1:0]    out_number_next;
    logic [rict_pkg::COUNT_W-1:0]  out_count_next;

    logic                         wr_key;
    logic                         wr_refs;
    logic [IDX_W-1:0]             sel_idx;
    logic [rict_pkg::COUNT_W-1:0] refs_next;
    logic [rict_pkg::COUNT_W-1:0] cur_refs;
    logic [rict_pkg::KEY_W-1:0]   cur_key;
    logic                         bad_slot;

    assign stat.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg  <= in_command;
            num_reg  <= in_number;
            slot_reg <= in_slot;
        end
    end

    // Match and first-free pick; the lowest slot wins in both.
    always_comb begin
        hit_next      = 1'b0;
        hit_idx_next  = '0;
        free_next     = 1'b0;
        free_idx_next = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (refs_reg[i] != '0) begin
                if (key_reg[i] == num_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = IDX_W'(i);
                end
            end else begin
                free_next     = 1'b1;
                free_idx_next = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            free_reg     <= free_next;
            free_idx_reg <= free_idx_next;
        end
    end

    assign bad_slot = 32'(slot_reg) >= 32'(SLOTS);

    always_comb begin
        if (cmd_reg == rict_pkg::CMD_PUT) begin
            sel_idx = slot_reg[IDX_W-1:0];
        end else if (hit_reg) begin
            sel_idx = hit_idx_reg;
        end else begin
            sel_idx = free_idx_reg;
        end
    end

    assign cur_refs = refs_reg[sel_idx];
    assign cur_key  = key_reg[sel_idx];

    always_comb begin
        wr_key          = 1'b0;
        wr_refs         = 1'b0;
        refs_next       = cur_refs;
        out_slot_next   = rict_pkg::SLOT_W'(sel_idx);
        out_status_next = rict_pkg::ST_FULL;
        out_number_next = '0;
        out_count_next  = '0;
        if (cmd_reg == rict_pkg::CMD_GET) begin
            if (hit_reg) begin
                out_number_next = num_reg;
                if (cur_refs == '1) begin
                    out_status_next = rict_pkg::ST_SAT;
                    out_count_next  = cur_refs;
                end else begin
                    wr_refs         = 1'b1;
                    refs_next       = cur_refs + rict_pkg::COUNT_W'(1);
                    out_status_next = rict_pkg::ST_HIT;
                    out_count_next  = refs_next;
                end
            end else if (free_reg) begin
                wr_key          = 1'b1;
                wr_refs         = 1'b1;
                refs_next       = rict_pkg::COUNT_W'(1);
                out_status_next = rict_pkg::ST_CLAIMED;
                out_number_next = num_reg;
                out_count_next  = refs_next;
            end else begin
                out_slot_next   = '0;
                out_status_next = rict_pkg::ST_FULL;
            end
        end else begin
            out_slot_next = slot_reg;
            if (bad_slot || cur_refs == '0) begin
                out_status_next = rict_pkg::ST_BADPUT;
            end else begin
                wr_refs         = 1'b1;
                refs_next       = cur_refs - rict_pkg::COUNT_W'(1);
                out_status_next = (refs_next == '0) ? rict_pkg::ST_LAST : rict_pkg::ST_STILL;
                out_number_next = cur_key;
                out_count_next  = refs_next;
            end
        end
    end

    // Counts are reset with the block; keys are only read behind a live count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                refs_reg[i] <= '0;
            end
        end else if (cmd.update && wr_refs) begin
            refs_reg[sel_idx] <= refs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && wr_key) begin
            key_reg[sel_idx] <= num_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            out_slot_reg   <= out_slot_next;
            out_status_reg <= out_status_next;
            out_number_reg <= out_number_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_count_reg, out_number_reg, out_slot_reg};

endmodule

@@ src/refcounted_inode_cache_table.sv @@
// ----------------------------------------------------------------------------
// refcounted_inode_cache_table
// Reference-counted table of inode entries with get and put operations.
// ----------------------------------------------------------------------------
// Flow: an accepted item is registered, then the lookup state runs the
// parallel key match and first-free pick over the table registers, and the
// update state applies the count update and loads the output register once
// it is free; a new item is taken as the previous result is loaded.
// Reset: all reference counts clear at once, so every entry is free; keys are
// not reset. The block accepts items in the first cycle after reset.
module refcounted_inode_cache_table #(
    parameter int TABLE_ENTRIES = rict_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] inode_number, [21:16] slot_in, [23:22] zero
    input  logic [rict_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] command
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [5:0] slot_out, [21:6] entry_number, [37:22] ref_count, [39:38] zero
    output logic [rict_pkg::M_TDATA_W-1:0]    m_tdata,
    // [2:0] status
    output logic [rict_pkg::STATUS_W-1:0]     m_tuser
);

    rict_pkg::ctrl_cmd_t   cmd;
    rict_pkg::dpath_stat_t stat;

    rict_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rict_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_command (s_tuser),
        .in_number  (s_tdata[15:0]),
        .in_slot    (s_tdata[21:16]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

@@ tb/refcounted_inode_cache_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_inode_cache_table_tb
// Self-checking bench for the inode cache table. Gets and puts go in as
// stream items. A shadow copy of the table predicts every result, and each
// result is checked field by field in order. The run has a directed table,
// a fill to capacity, a random mix with phases of varying get bias and a
// full drain.
// ----------------------------------------------------------------------------
module refcounted_inode_cache_table_tb;

    localparam int TABLE_SLOTS    = (rict_pkg::TABLE_ENTRIES_DEF < rict_pkg::SLOT_LIMIT) ?
                                    rict_pkg::TABLE_ENTRIES_DEF : rict_pkg::SLOT_LIMIT;
    localparam logic [rict_pkg::COUNT_W-1:0] COUNT_TOP = '1;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int KEY_POOL_SIZE  = 96;
    localparam int DIRECTED_COUNT = 21;

    typedef struct packed {
        logic [rict_pkg::SLOT_W-1:0]   slot;
        logic [rict_pkg::STATUS_W-1:0] status;
        logic [rict_pkg::KEY_W-1:0]    number;
        logic [rict_pkg::COUNT_W-1:0]  count;
    } table_result_t;

    typedef struct packed {
        logic                          cmd;
        logic [rict_pkg::KEY_W-1:0]    num;
        logic [rict_pkg::SLOT_W-1:0]   slot;
        logic                          typed;
        table_result_t                 result;
    } stim_row_t;

    // Rows with typed results start from an empty table and follow one another.
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{rict_pkg::CMD_PUT, 16'h0000, 6'd0,  1'b1,
          '{6'd0,  rict_pkg::ST_BADPUT,  16'h0000, 16'd0}},
        '{rict_pkg::CMD_PUT, 16'hFFFF, 6'd63, 1'b1,
          '{6'd63, rict_pkg::ST_BADPUT,  16'h0000, 16'd0}},
        '{rict_pkg::CMD_GET, 16'h0000, 6'd63, 1'b1,
          '{6'd0,  rict_pkg::ST_CLAIMED, 16'h0000, 16'd1}},
        '{rict_pkg::CMD_GET, 16'hFFFF, 6'd0,  1'b1,
          '{6'd1,  rict_pkg::ST_CLAIMED, 16'hFFFF, 16'd1}},
        '{rict_pkg::CMD_GET, 16'h0000, 6'd0,  1'b1,
          '{6'd0,  rict_pkg::ST_HIT,     16'h0000, 16'd2}},
        '{rict_pkg::CMD_GET, 16'hFFFF, 6'd0,  1'b1,
          '{6'd1,  rict_pkg::ST_HIT,     16'hFFFF, 16'd2}},
        '{rict_pkg::CMD_PUT, 16'hFFFF, 6'd0,  1'b1,
          '{6'd0,  rict_pkg::ST_STILL,   16'h0000, 16'd1}},
        '{rict_pkg::CMD_PUT, 16'h0000, 6'd0,  1'b1,
          '{6'd0,  rict_pkg::ST_LAST,    16'h0000, 16'd0}},
        '{rict_pkg::CMD_PUT, 16'h0000, 6'd0,  1'b1,
          '{6'd0,  rict_pkg::ST_BADPUT,  16'h0000, 16'd0}},
        // The stale key in slot 0 must not match; the get claims it afresh.
        '{rict_pkg::CMD_GET, 16'h0000, 6'd0,  1'b1,
          '{6'd0,  rict_pkg::ST_CLAIMED, 16'h0000, 16'd1}},
        '{rict_pkg::CMD_GET, 16'h5A5A, 6'd0,  1'b1,
          '{6'd2,  rict_pkg::ST_CLAIMED, 16'h5A5A, 16'd1}},
        '{rict_pkg::CMD_GET, 16'hA5A5, 6'd0,  1'b1,
          '{6'd3,  rict_pkg::ST_CLAIMED, 16'hA5A5, 16'd1}},
        '{rict_pkg::CMD_PUT, 16'h0000, 6'd2,  1'b1,
          '{6'd2,  rict_pkg::ST_LAST,    16'h5A5A, 16'd0}},
        '{rict_pkg::CMD_GET, 16'h1234, 6'd0,  1'b1,
          '{6'd2,  rict_pkg::ST_CLAIMED, 16'h1234, 16'd1}},
        '{rict_pkg::CMD_GET, 16'hA5A5, 6'd0,  1'b1,
          '{6'd3,  rict_pkg::ST_HIT,     16'hA5A5, 16'd2}},
        '{rict_pkg::CMD_PUT, 16'h0000, 6'd1,  1'b1,
          '{6'd1,  rict_pkg::ST_STILL,   16'hFFFF, 16'd1}},
        '{rict_pkg::CMD_PUT, 16'h0000, 6'd1,  1'b1,
          '{6'd1,  rict_pkg::ST_LAST,    16'hFFFF, 16'd0}},
        '{rict_pkg::CMD_GET, 16'hFFFF, 6'd0,  1'b1,
          '{6'd1,  rict_pkg::ST_CLAIMED, 16'hFFFF, 16'd1}},
        '{rict_pkg::CMD_PUT, 16'h0000, 6'd40, 1'b1,
          '{6'd40, rict_pkg::ST_BADPUT,  16'h0000, 16'd0}},
        '{rict_pkg::CMD_GET, 16'h0001, 6'd42, 1'b0, '0},
        '{rict_pkg::CMD_PUT, 16'h8000, 6'd3,  1'b0, '0}
    };

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rict_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rict_pkg::M_TDATA_W-1:0] m_tdata;
    logic [rict_pkg::STATUS_W-1:0]  m_tuser;

    logic [rict_pkg::KEY_W-1:0]     shadow_key  [TABLE_SLOTS];
    logic [rict_pkg::COUNT_W-1:0]   shadow_refs [TABLE_SLOTS];
    logic [rict_pkg::KEY_W-1:0]     key_pool    [KEY_POOL_SIZE];

    table_result_t        pending_table_results [$];
    int unsigned          mismatch_count = 0;
    int unsigned          items_sent     = 0;
    int unsigned          results_seen   = 0;
    int unsigned          status_seen [8];

    refcounted_inode_cache_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic table_result_t predict_table_access(
        input logic                        cmd,
        input logic [rict_pkg::KEY_W-1:0]  num,
        input logic [rict_pkg::SLOT_W-1:0] slot
    );
        table_result_t r;
        int hit_at;
        int free_at;
        int i;
        r       = '0;
        hit_at  = -1;
        free_at = -1;
        if (cmd == rict_pkg::CMD_GET) begin
            for (i = 0; i < TABLE_SLOTS; i++) begin
                if (shadow_refs[i] != '0) begin
                    if (hit_at < 0 && shadow_key[i] == num) begin
                        hit_at = i;
                    end
                end else if (free_at < 0) begin
                    free_at = i;
                end
            end
            if (hit_at >= 0) begin
                r.slot   = rict_pkg::SLOT_W'(hit_at);
                r.number = shadow_key[hit_at];
                if (shadow_refs[hit_at] == COUNT_TOP) begin
                    r.status = rict_pkg::ST_SAT;
                end else begin
                    shadow_refs[hit_at] = shadow_refs[hit_at] + rict_pkg::COUNT_W'(1);
                    r.status = rict_pkg::ST_HIT;
                end
                r.count = shadow_refs[hit_at];
            end else if (free_at >= 0) begin
                shadow_key[free_at]  = num;
                shadow_refs[free_at] = rict_pkg::COUNT_W'(1);
                r.slot   = rict_pkg::SLOT_W'(free_at);
                r.status = rict_pkg::ST_CLAIMED;
                r.number = num;
                r.count  = rict_pkg::COUNT_W'(1);
            end else begin
                r.status = rict_pkg::ST_FULL;
            end
        end else begin
            r.slot = slot;
            if (int'(slot) >= TABLE_SLOTS || shadow_refs[slot] == '0) begin
                r.status = rict_pkg::ST_BADPUT;
            end else begin
                shadow_refs[slot] = shadow_refs[slot] - rict_pkg::COUNT_W'(1);
                r.status = (shadow_refs[slot] == '0) ? rict_pkg::ST_LAST : rict_pkg::ST_STILL;
                r.number = shadow_key[slot];
                r.count  = shadow_refs[slot];
            end
        end
        return r;
    endfunction

    function automatic int live_slot_of(input logic [rict_pkg::KEY_W-1:0] key);
        int i;
        for (i = 0; i < TABLE_SLOTS; i++) begin
            if (shadow_refs[i] != '0 && shadow_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [rict_pkg::KEY_W-1:0] fresh_key();
        logic [rict_pkg::KEY_W-1:0] key;
        do begin
            key = rict_pkg::KEY_W'($urandom);
        end while (live_slot_of(key) >= 0);
        return key;
    endfunction

    function automatic int pick_live_slot();
        int live [$];
        int i;
        for (i = 0; i < TABLE_SLOTS; i++) begin
            if (shadow_refs[i] != '0) begin
                live.push_back(i);
            end
        end
        if (live.size() == 0) begin
            return -1;
        end
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Called right after a rising edge; returns at the edge that accepts the item.
    task automatic send_item(
        input  logic                        cmd,
        input  logic [rict_pkg::KEY_W-1:0]  num,
        input  logic [rict_pkg::SLOT_W-1:0] slot,
        output table_result_t               predicted
    );
        int unsigned gap;
        gap = $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= cmd;
        s_tdata  <= {{(rict_pkg::S_TDATA_W - rict_pkg::KEY_W - rict_pkg::SLOT_W){1'b0}},
                     slot, num};
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!(s_tvalid && s_tready));
        items_sent++;
        predicted = predict_table_access(cmd, num, slot);
    endtask

    task automatic issue(
        input logic                        cmd,
        input logic [rict_pkg::KEY_W-1:0]  num,
        input logic [rict_pkg::SLOT_W-1:0] slot
    );
        table_result_t predicted;
        send_item(cmd, num, slot, predicted);
        pending_table_results.push_back(predicted);
    endtask

    task automatic check_result();
        table_result_t got;
        table_result_t want;
        got.slot   = m_tdata[rict_pkg::SLOT_W-1:0];
        got.number = m_tdata[rict_pkg::SLOT_W +: rict_pkg::KEY_W];
        got.count  = m_tdata[rict_pkg::SLOT_W + rict_pkg::KEY_W +: rict_pkg::COUNT_W];
        got.status = m_tuser;
        status_seen[got.status]++;
        if (pending_table_results.size() == 0) begin
            $error("result with no item outstanding: status %0d slot %0d",
                   got.status, got.slot);
            mismatch_count++;
        end else begin
            want = pending_table_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatch_count++;
            end
            if (got.slot !== want.slot) begin
                $error("slot_out: expected %0d, got %0d", want.slot, got.slot);
                mismatch_count++;
            end
            if (got.number !== want.number) begin
                $error("entry_number: expected %h, got %h", want.number, got.number);
                mismatch_count++;
            end
            if (got.count !== want.count) begin
                $error("ref_count: expected %0d, got %0d", want.count, got.count);
                mismatch_count++;
            end
        end
    endtask

    // Result side: a random stall after each item, and now and then a long
    // hold-off so the block backs up into its input.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_tvalid && m_tready) begin
                    check_result();
                    results_seen++;
                    if (results_seen % 400 == 100) begin
                        stall_left = 300;
                    end else begin
                        stall_left = $urandom_range(0, 19);
                    end
                end
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        table_result_t               predicted;
        stim_row_t                   row;
        logic [rict_pkg::KEY_W-1:0]  key;
        logic [rict_pkg::SLOT_W-1:0] slot;
        int                          live;
        int                          n;
        int unsigned                 get_pct;
        for (n = 0; n < TABLE_SLOTS; n++) begin
            shadow_refs[n] = '0;
        end
        for (n = 0; n < KEY_POOL_SIZE; n++) begin
            key_pool[n] = rict_pkg::KEY_W'($urandom);
        end
        for (n = 0; n < 8; n++) begin
            status_seen[n] = 0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (n = 0; n < DIRECTED_COUNT; n++) begin
            row = DIRECTED_ROWS[n];
            send_item(row.cmd, row.num, row.slot, predicted);
            pending_table_results.push_back(row.typed ? row.result : predicted);
        end

        // Fill every free entry, then keep asking so the table reports full.
        for (n = 0; n < TABLE_SLOTS; n++) begin
            issue(rict_pkg::CMD_GET, fresh_key(), rict_pkg::SLOT_W'($urandom));
        end
        issue(rict_pkg::CMD_GET, shadow_key[10], '0);
        issue(rict_pkg::CMD_PUT, '0, rict_pkg::SLOT_W'(TABLE_SLOTS - 1));
        issue(rict_pkg::CMD_GET, fresh_key(), '0);

        // The get bias steps through low, middle and high so that the table
        // drains and refills several times.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            get_pct = (n / 100) % 3 == 0 ? 30 : ((n / 100) % 3 == 1 ? 55 : 80);
            if ($urandom_range(1, 100) <= get_pct) begin
                if ($urandom_range(0, 9) < 7) begin
                    key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
                end else begin
                    key = rict_pkg::KEY_W'($urandom);
                end
                issue(rict_pkg::CMD_GET, key, rict_pkg::SLOT_W'($urandom));
            end else begin
                live = pick_live_slot();
                if (live < 0 || $urandom_range(0, 6) == 0) begin
                    slot = rict_pkg::SLOT_W'($urandom);
                end else begin
                    slot = rict_pkg::SLOT_W'(live);
                end
                issue(rict_pkg::CMD_PUT, rict_pkg::KEY_W'($urandom), slot);
            end
        end

        for (n = 0; n < TABLE_SLOTS; n++) begin
            while (shadow_refs[n] != '0) begin
                issue(rict_pkg::CMD_PUT, rict_pkg::KEY_W'($urandom), rict_pkg::SLOT_W'(n));
            end
        end

        s_tvalid <= 1'b0;
        while (pending_table_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        $display("Run covered %0d items and %0d results: directed cases, a fill to capacity,",
                 items_sent, results_seen);
        $display("a random get and put mix under random stalls, and a drain to empty.");
        $display("Results: hit %0d, claimed %0d, full %0d, last %0d,",
                 status_seen[rict_pkg::ST_HIT], status_seen[rict_pkg::ST_CLAIMED],
                 status_seen[rict_pkg::ST_FULL], status_seen[rict_pkg::ST_LAST]);
        $display("still %0d, bad put %0d, saturated %0d.",
                 status_seen[rict_pkg::ST_STILL], status_seen[rict_pkg::ST_BADPUT],
                 status_seen[rict_pkg::ST_SAT]);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d results still outstanding.", pending_table_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
